@@ rtl/core/frpr_pkg.sv @@
// shared types and constants of the four-register program runner
package frpr_pkg;

  // stream widths
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 128;
  localparam int OPND_W = 32;
  localparam int JUMP_TARGET_W = 5;

  // instruction queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_A = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_B = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_C = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_D = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LIMIT = 3'd4;
  localparam logic [CFG_DATA_W-1:0] STEP_LIMIT_RESET = 32'd1000000;

  typedef enum logic [1:0] {
    OP_MOV = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_JNE = 2'd3
  } opcode_t;

  // control word of one program slot
  typedef struct packed {
    logic [JUMP_TARGET_W-1:0] jump_target;
    logic                     second_is_imm;
    logic                     first_is_imm;
    logic [1:0]               dest_reg;
    opcode_t                  opcode;
  } ctl_t;

  typedef struct packed {
    logic [OPND_W-1:0] second_value;
    logic [OPND_W-1:0] first_value;
    ctl_t              ctl;
  } instr_t;

  // queue entry: instruction plus what the front decided about it
  typedef struct packed {
    logic   last;
    logic   store;
    instr_t instr;
  } entry_t;

endpackage

@@ rtl/core/frpr_front.sv @@
// front end: accepts instruction requests, tracks load fill, tags for the back end
module frpr_front
  import frpr_pkg::*;
#(
  parameter int PROGRAM_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // opcode[1:0] dest_reg[3:2] first_is_imm[4] first_value[36:5]
  // second_is_imm[37] second_value[69:38] jump_target[74:70], zero pad above
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tlast,
  input  logic                 q_full,
  output logic                 q_push,
  output entry_t               q_entry
);

  localparam int CW = ($clog2(PROGRAM_DEPTH + 1) > 1) ? $clog2(PROGRAM_DEPTH + 1) : 1;

  logic [CW-1:0] fill_count;
  logic          accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept;

  // unpack the request and mark whether it fits in the program store
  always_comb begin
    q_entry.instr.ctl.opcode        = opcode_t'(s_tdata[1:0]);
    q_entry.instr.ctl.dest_reg      = s_tdata[3:2];
    q_entry.instr.ctl.first_is_imm  = s_tdata[4];
    q_entry.instr.first_value       = s_tdata[36:5];
    q_entry.instr.ctl.second_is_imm = s_tdata[37];
    q_entry.instr.second_value      = s_tdata[69:38];
    q_entry.instr.ctl.jump_target   = s_tdata[74:70];
    q_entry.store                   = (fill_count < CW'(PROGRAM_DEPTH));
    q_entry.last                    = s_tlast;
  end

  // count of slots used by the load in progress
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        fill_count <= '0;
      end else if (fill_count < CW'(PROGRAM_DEPTH)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/frpr_queue.sv @@
// two-entry instruction queue between front and back end
module frpr_queue
  import frpr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t entry_in,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output entry_t entry_out
);

  entry_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign full      = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign valid     = (count != '0);
  assign entry_out = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
    else $error("queue holds more entries than it has");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_pop_has_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("pop from an empty queue");

endmodule

@@ rtl/core/frpr_back.sv @@
// back end: program store, register file, execution sequencer and result register
module frpr_back
  import frpr_pkg::*;
#(
  parameter int PROGRAM_DEPTH = 16,
  parameter int WORD_WIDTH    = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   q_valid,
  input  entry_t                 q_entry,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,
  output logic                   m_tuser
);

  localparam int AW = ($clog2(PROGRAM_DEPTH) > 0) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int PW = ($clog2(PROGRAM_DEPTH + 1) > JUMP_TARGET_W) ?
                      $clog2(PROGRAM_DEPTH + 1) : JUMP_TARGET_W;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_START = 4'b0010,
    S_RUN   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                state;
  ctl_t                  ctl_mem  [PROGRAM_DEPTH];
  logic [OPND_W-1:0]     opnd1_mem [PROGRAM_DEPTH];
  logic [OPND_W-1:0]     opnd2_mem [PROGRAM_DEPTH];
  ctl_t                  rd_ctl;
  logic [OPND_W-1:0]     rd_opnd1;
  logic [OPND_W-1:0]     rd_opnd2;
  logic [AW-1:0]         rd_addr;
  logic [WORD_WIDTH-1:0] regs [4];
  logic [WORD_WIDTH-1:0] start_regs [4];
  logic [CFG_DATA_W-1:0] step_limit;
  logic [CFG_DATA_W-1:0] steps;
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         prog_len;
  logic [PW-1:0]         pc;
  logic [PW-1:0]         pc_next;
  logic                  timed_out;
  logic                  mem_we;
  logic                  run_end;
  logic                  run_timeout;
  logic                  exec;
  logic                  jne_taken;
  logic [WORD_WIDTH-1:0] src_x;
  logic [WORD_WIDTH-1:0] src_y;
  logic [WORD_WIDTH-1:0] alu_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        start_regs[i] <= '0;
      end
      step_limit <= STEP_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_A:    start_regs[0] <= WORD_WIDTH'(signed'(cfg_data));
        CFG_START_B:    start_regs[1] <= WORD_WIDTH'(signed'(cfg_data));
        CFG_START_C:    start_regs[2] <= WORD_WIDTH'(signed'(cfg_data));
        CFG_START_D:    start_regs[3] <= WORD_WIDTH'(signed'(cfg_data));
        CFG_STEP_LIMIT: step_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // queue drain while loading
  assign q_pop  = (state == S_LOAD) && q_valid;
  assign mem_we = q_pop && q_entry.store;

  // operand fetch, each immediate on its own
  assign src_x = rd_ctl.first_is_imm ? WORD_WIDTH'(signed'(rd_opnd1)) : regs[rd_opnd1[1:0]];
  assign src_y = rd_ctl.second_is_imm ? WORD_WIDTH'(signed'(rd_opnd2)) : regs[rd_opnd2[1:0]];

  // end-of-run checks, program end before step limit
  assign run_end     = (pc >= prog_len);
  assign run_timeout = (steps >= step_limit);
  assign exec        = (state == S_RUN) && !run_end && !run_timeout;

  // alu
  always_comb begin
    unique case (rd_ctl.opcode)
      OP_MOV:  alu_out = src_x;
      OP_ADD:  alu_out = src_x + src_y;
      OP_SUB:  alu_out = src_x - src_y;
      OP_JNE:  alu_out = src_x;
      default: alu_out = src_x;
    endcase
  end

  // next program counter and fetch address for the following cycle
  assign jne_taken = (rd_ctl.opcode == OP_JNE) && (src_x != src_y);
  assign pc_next   = jne_taken ? PW'(rd_ctl.jump_target) : pc + 1'b1;

  always_comb begin
    rd_addr = '0;
    if (state == S_RUN && pc_next < PW'(PROGRAM_DEPTH)) begin
      rd_addr = pc_next[AW-1:0];
    end
  end

  // program store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ctl_mem[wr_ptr[AW-1:0]]   <= q_entry.instr.ctl;
      opnd1_mem[wr_ptr[AW-1:0]] <= q_entry.instr.first_value;
      opnd2_mem[wr_ptr[AW-1:0]] <= q_entry.instr.second_value;
    end
    rd_ctl   <= ctl_mem[rd_addr];
    rd_opnd1 <= opnd1_mem[rd_addr];
    rd_opnd2 <= opnd2_mem[rd_addr];
  end

  // register file
  always_ff @(posedge clk) begin
    if (q_pop && q_entry.last) begin
      for (int i = 0; i < 4; i++) begin
        regs[i] <= start_regs[i];
      end
    end else if (exec && rd_ctl.opcode != OP_JNE) begin
      regs[rd_ctl.dest_reg] <= alu_out;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      wr_ptr    <= '0;
      prog_len  <= '0;
      pc        <= '0;
      steps     <= '0;
      timed_out <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (q_valid) begin
            if (q_entry.last) begin
              prog_len <= wr_ptr + PW'(q_entry.store);
              wr_ptr   <= '0;
              pc       <= '0;
              steps    <= '0;
              state    <= S_START;
            end else if (q_entry.store) begin
              wr_ptr <= wr_ptr + 1'b1;
            end
          end
        end
        S_START: begin
          state <= S_RUN;
        end
        S_RUN: begin
          priority if (run_end) begin
            timed_out <= 1'b0;
            state     <= S_DONE;
          end else if (run_timeout) begin
            timed_out <= 1'b1;
            state     <= S_DONE;
          end else begin
            pc    <= pc_next;
            steps <= steps + 1'b1;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // result valid: raised when a finished run is posted, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {32'(regs[3]), 32'(regs[2]), 32'(regs[1]), 32'(regs[0])};
      m_tuser <= timed_out;
    end
  end

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= PW'(PROGRAM_DEPTH))
    else $error("program store write pointer past depth");

  a_start_after_load: assert property (@(posedge clk) disable iff (rst)
    state == S_START |-> $past(state) == S_LOAD)
    else $error("run started without a load");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result shown without a finished run");

endmodule

@@ rtl/core/four_register_program_runner.sv @@
// top level of the four-register program runner
// Loads a program of up to PROGRAM_DEPTH instructions, one request per cycle,
// the request with tlast ending the load; then runs it from slot 0 on four
// WORD_WIDTH-bit registers preset by configuration and returns the four final
// values (low 32 bits each) with a timeout flag in tuser. Requests pass
// through a two-entry queue into the program store. A run passes through
// a start state, then executes with the program store read at the next
// program counter, stops at the program end or the step limit and posts
// the result once the previous one is taken. While a run is busy the queue
// fills and s_tready drops. Configuration is taken on any cycle with cfg_we.
module four_register_program_runner
  import frpr_pkg::*;
#(
  parameter int PROGRAM_DEPTH = 16,
  parameter int WORD_WIDTH    = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // opcode[1:0] dest_reg[3:2] first_is_imm[4] first_value[36:5]
  // second_is_imm[37] second_value[69:38] jump_target[74:70], zero pad above
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // last_instruction
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // final_a[31:0] final_b[63:32] final_c[95:64] final_d[127:96]
  output logic [M_TDATA_W-1:0]   m_tdata,
  // timed_out
  output logic                   m_tuser
);

  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t entry_in;
  entry_t entry_out;

  // request intake
  frpr_front #(
    .PROGRAM_DEPTH(PROGRAM_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .q_full  (full),
    .q_push  (push),
    .q_entry (entry_in)
  );

  // decoupling queue
  frpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .entry_in (entry_in),
    .full     (full),
    .pop      (pop),
    .valid    (q_valid),
    .entry_out(entry_out)
  );

  // program store and execution
  frpr_back #(
    .PROGRAM_DEPTH(PROGRAM_DEPTH),
    .WORD_WIDTH   (WORD_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_entry  (entry_out),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
